@@ design/grc_pkg.sv @@
package grc_pkg;

  // Map geometry
  localparam int MAP_BITS  = 6;
  localparam int MAP_SIDE  = 1 << MAP_BITS;
  localparam int ADDR_W    = 2 * MAP_BITS;
  localparam int MAP_DEPTH = 1 << ADDR_W;
  localparam int CELL_W    = 4;

  // Word field widths
  localparam int POS_W      = 16;
  localparam int POS_FRAC   = 10;
  localparam int ANGLE_W    = 12;
  localparam int PHASE_W    = 16;
  localparam int DEPTH_W    = 16;
  localparam int HEIGHT_W   = 16;
  localparam int OFFSET_W   = 10;

  // Configuration registers
  localparam int SD_W       = 12;
  localparam int STEPS_W    = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_DISTANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS       = 1'b1;
  localparam logic [SD_W-1:0]      SD_RESET            = 12'd1386;
  localparam logic [STEPS_W-1:0]   STEPS_RESET         = 6'd20;

  // Arithmetic widths
  localparam int TRIG_W  = 16;   // signed Q1.14
  localparam int DIV_W   = 38;   // divider operands, distances
  localparam int DCNT_W  = $clog2(DIV_W);
  localparam int MUL_A_W = 21;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SPLIT   = 20;   // low slice of a wide multiplicand
  localparam int WIDE_W  = 56;
  localparam int ACR_W   = 48;
  localparam int LINE_W  = 10;
  localparam int REM_W   = 15;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SIN_A,
    ST_SIN_B,
    ST_SIN_C,
    ST_SIN_D,
    ST_SIN_E,
    ST_W_INIT,
    ST_W_Q0,
    ST_W_STEP,
    ST_W_P0,
    ST_W_QSC,
    ST_W_ACR,
    ST_W_LOOK,
    ST_W_TEST,
    ST_W_END,
    ST_PICK,
    ST_CORR,
    ST_PH,
    ST_PH_DONE,
    ST_OUT,
    ST_DIV,
    ST_WM_LO,
    ST_WM_HI,
    ST_WM_SUM
  } state_t;

endpackage

@@ design/grc_if.sv @@
interface grc_req_if import grc_pkg::*;;
  logic                valid;
  logic                ready;
  logic                op;
  logic [MAP_BITS-1:0] cell_x;
  logic [MAP_BITS-1:0] cell_y;
  logic [CELL_W-1:0]   cell_value;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;
  logic [ANGLE_W-1:0]  beam_angle;
  logic [ANGLE_W-1:0]  view_angle;

  modport source (output valid, op, cell_x, cell_y, cell_value, pos_x, pos_y,
                  beam_angle, view_angle, input ready);
  modport sink (input valid, op, cell_x, cell_y, cell_value, pos_x, pos_y,
                beam_angle, view_angle, output ready);
endinterface

interface grc_rsp_if import grc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [DEPTH_W-1:0]  depth;
  logic [HEIGHT_W-1:0] wall_height;
  logic [CELL_W-1:0]   wall_code;
  logic [OFFSET_W-1:0] hit_offset;
  logic                hit_vertical;

  modport source (output valid, depth, wall_height, wall_code, hit_offset,
                  hit_vertical, input ready);
  modport sink (input valid, depth, wall_height, wall_code, hit_offset,
                hit_vertical, output ready);
endinterface

@@ design/grc_ram.sv @@
module grc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/grid_ray_caster.sv @@
// Grid ray caster. A write word (op 0) stores a 4-bit wall code in the 64x64 map and
// gives no result. A cast word (op 1) walks the horizontal and then the vertical grid
// crossings of one ray, up to max_steps each, and returns one result word: the nearer
// hit with fish-bowl corrected Q8.8 depth, projected height, texture code (1 on no hit),
// face offset and face orientation. A cast runs the bit-serial divider up to five times
// per ray and reads the single map read port once per crossing looked up. After reset
// the map is swept to empty, one cell per cycle, through all 4096 cells, during which no
// word is taken; configuration writes are taken at any time.
module grid_ray_caster import grc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  grc_req_if.sink               req,
  grc_rsp_if.source             rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next, ret_state;

  logic [SD_W-1:0]    screen_distance;
  logic [STEPS_W-1:0] max_steps;
  logic [ADDR_W-1:0]  clr_addr;

  // Ray registers
  logic [POS_W-1:0]   ray_x, ray_y;
  logic [PHASE_W-1:0] ray_phase, view_phase;
  logic [1:0]         sin_sel;
  logic [REM_W-1:0]   sin_x2;
  logic signed [TRIG_W-1:0] sin_r, cos_r, fb_cos;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [MUL_A_W-1:0] p14;

  // Wide multiply sequence
  logic [DIV_W-1:0]          wm_a;
  logic signed [MUL_B_W-1:0] wm_b;
  logic signed [PROD_W-1:0]  wm_acc;
  logic signed [WIDE_W-1:0]  wm_res;

  // Bit-serial divider
  logic [DIV_W-1:0]  div_quo, div_rem, div_den;
  logic [DCNT_W-1:0] div_cnt;
  logic [DIV_W:0]    div_sh;
  logic              div_ge;

  // Walk datapath
  logic                     wsel;
  logic                     w_fin;
  logic [DIV_W-1:0]         w_q, w_bq;
  logic [REM_W-1:0]         w_r, w_br;
  logic signed [WIDE_W-1:0] w_p, w_qsc;
  logic signed [ACR_W-1:0]  w_acr, w_acr_next;
  logic signed [LINE_W-1:0] w_cm;
  logic [STEPS_W-1:0]       w_i;
  logic [CELL_W-1:0]        w_tex, w_v;
  logic                     w_inr;
  logic signed [TRIG_W-1:0] w_sm, w_sc, w_neg;
  logic [POS_W-1:0]         w_pm, w_pc;
  logic                     w_dir_pos;
  logic [REM_W-1:0]         w_den;
  logic [POS_FRAC:0]        w_f;
  logic [REM_W:0]           w_rsum;
  logic                     w_carry;
  logic                     w_at_end;
  logic                     w_in_map;

  // Walk results
  logic [DIV_W-1:0] h_dist, v_dist;
  logic [15:0]      h_frac, v_frac;
  logic [CELL_W-1:0] h_tex, v_tex;
  logic             h_fin, v_fin;

  // Final stage
  logic              use_vert;
  logic [15:0]       pick_frac;
  logic              pick_flip;
  logic [16:0]       off17;
  logic [DIV_W-1:0]  corr;
  logic signed [WIDE_W-1:0] corr_w;
  logic [CELL_W-1:0]   r_tex;
  logic                r_vert;
  logic [OFFSET_W-1:0] r_off;
  logic [HEIGHT_W-1:0] r_ph;

  // Output word register
  logic                out_valid;
  logic [DEPTH_W-1:0]  out_depth;
  logic [HEIGHT_W-1:0] out_height;
  logic [CELL_W-1:0]   out_tex;
  logic [OFFSET_W-1:0] out_off;
  logic                out_vert;

  // Map memory ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // Sine operand for the current phase
  logic [PHASE_W-1:0] sin_phase;
  logic [REM_W-1:0]   sin_x;
  logic               sin_neg;
  logic signed [TRIG_W-1:0] sin_mag;

  logic req_acc;

  grc_ram #(.WIDTH(CELL_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_acc = req.valid && req.ready;

  // Sine argument folding
  always_comb begin
    case (sin_sel)
      2'd0:    sin_phase = ray_phase;
      2'd1:    sin_phase = ray_phase + 16'd16384;
      default: sin_phase = view_phase - ray_phase + 16'd16384;
    endcase
    sin_neg = sin_phase[15];
    sin_x   = sin_phase[14] ? (15'd16384 - {1'b0, sin_phase[13:0]})
                            : {1'b0, sin_phase[13:0]};
  end

  assign p14     = {1'b0, prod[14+MUL_A_W-2:14]};
  assign sin_mag = p14[TRIG_W-1:0];

  // Walk roles: horizontal walk steps along y, vertical along x
  always_comb begin
    w_sm      = wsel ? cos_r : sin_r;
    w_sc      = wsel ? sin_r : cos_r;
    w_pm      = wsel ? ray_x : ray_y;
    w_pc      = wsel ? ray_y : ray_x;
    w_neg     = -w_sm;
    w_dir_pos = (w_sm > 0);
    w_den     = w_sm[TRIG_W-1] ? w_neg[REM_W-1:0] : w_sm[REM_W-1:0];
    w_f       = w_dir_pos ? (11'd1024 - {1'b0, w_pm[POS_FRAC-1:0]})
                          : {1'b0, w_pm[POS_FRAC-1:0]};
    w_acr_next = ACR_W'($signed({1'b0, w_pc, 6'b0})) + ACR_W'(w_p >>> 14);
    w_rsum    = {1'b0, w_r} + {1'b0, w_br};
    w_carry   = (w_rsum >= {1'b0, w_den});
    w_at_end  = (w_i >= max_steps);
    w_in_map  = (w_acr[ACR_W-1:16+MAP_BITS] == '0) &&
                (w_cm[LINE_W-1:MAP_BITS] == '0);
    w_v       = w_inr ? ram_rdata : '0;
  end

  // Divider step
  assign div_sh = {div_rem, div_quo[DIV_W-1]};
  assign div_ge = (div_sh >= {1'b0, div_den});

  // Nearer hit and face offset
  always_comb begin
    use_vert  = v_fin && (!h_fin || (v_dist < h_dist));
    pick_frac = use_vert ? v_frac : h_frac;
    pick_flip = use_vert ? !(cos_r > 0) : (sin_r > 0);
    off17     = pick_flip ? (17'h10000 - {1'b0, pick_frac}) : {1'b0, pick_frac};
    corr_w    = wm_res >>> 14;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (clr_addr == ADDR_W'(MAP_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:    if (req_acc && req.op) state_next = ST_SIN_A;
      ST_SIN_A:   state_next = ST_SIN_B;
      ST_SIN_B:   state_next = ST_SIN_C;
      ST_SIN_C:   state_next = ST_SIN_D;
      ST_SIN_D:   state_next = ST_SIN_E;
      ST_SIN_E:   state_next = (sin_sel == 2'd2) ? ST_W_INIT : ST_SIN_A;
      ST_W_INIT:  state_next = (w_sm == 0) ? ST_W_END : ST_DIV;
      ST_W_Q0:    state_next = ST_DIV;
      ST_W_STEP:  state_next = ST_WM_LO;
      ST_W_P0:    state_next = ST_WM_LO;
      ST_W_QSC:   state_next = ST_W_ACR;
      ST_W_ACR:   state_next = ST_W_LOOK;
      ST_W_LOOK:  state_next = w_at_end ? ST_W_END : ST_W_TEST;
      ST_W_TEST:  state_next = (w_v != '0) ? ST_W_END : ST_W_ACR;
      ST_W_END:   state_next = wsel ? ST_PICK : ST_W_INIT;
      ST_PICK:    state_next = ST_WM_LO;
      ST_CORR:    state_next = ST_PH;
      ST_PH:      state_next = (corr == '0) ? ST_OUT : ST_DIV;
      ST_PH_DONE: state_next = ST_OUT;
      ST_OUT:     if (!out_valid || rsp.ready) state_next = ST_IDLE;
      ST_DIV:     if (div_cnt == DCNT_W'(DIV_W - 1)) state_next = ret_state;
      ST_WM_LO:   state_next = ST_WM_HI;
      ST_WM_HI:   state_next = ST_WM_SUM;
      ST_WM_SUM:  state_next = ret_state;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Control outputs: handshake, map ports, multiplier operands
  always_comb begin
    req.ready = (state == ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = {req.cell_y, req.cell_x};
    ram_wdata = req.cell_value;
    ram_raddr = wsel ? {w_acr[16+MAP_BITS-1:16], w_cm[MAP_BITS-1:0]}
                     : {w_cm[MAP_BITS-1:0], w_acr[16+MAP_BITS-1:16]};
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_IDLE:  ram_we = req_acc && !req.op;
      ST_SIN_A: begin
        mul_a = MUL_A_W'(sin_x);
        mul_b = MUL_B_W'(sin_x);
      end
      ST_SIN_B: begin
        mul_a = p14;
        mul_b = 17'sd1160;
      end
      ST_SIN_C: begin
        mul_a = 21'sd10512 - p14;
        mul_b = MUL_B_W'(sin_x2);
      end
      ST_SIN_D: begin
        mul_a = 21'sd25736 - p14;
        mul_b = MUL_B_W'(sin_x);
      end
      ST_WM_LO: begin
        mul_a = MUL_A_W'(wm_a[SPLIT-1:0]);
        mul_b = wm_b;
      end
      ST_WM_HI: begin
        mul_a = MUL_A_W'(wm_a[DIV_W-1:SPLIT]);
        mul_b = wm_b;
      end
      default: ;
    endcase
  end

  // Output word
  assign rsp.valid        = out_valid;
  assign rsp.depth        = out_depth;
  assign rsp.wall_height  = out_height;
  assign rsp.wall_code    = out_tex;
  assign rsp.hit_offset   = out_off;
  assign rsp.hit_vertical = out_vert;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_addr        <= '0;
      screen_distance <= SD_RESET;
      max_steps       <= STEPS_RESET;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cfg_we && cfg_index == CFG_SCREEN_DISTANCE) screen_distance <= cfg_data[SD_W-1:0];
      if (cfg_we && cfg_index == CFG_MAX_STEPS) max_steps <= cfg_data[STEPS_W-1:0];
      if (state == ST_OUT && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        ray_x      <= req.pos_x;
        ray_y      <= req.pos_y;
        ray_phase  <= {req.beam_angle, (PHASE_W - ANGLE_W)'(0)};
        view_phase <= {req.view_angle, (PHASE_W - ANGLE_W)'(0)};
        sin_sel    <= 2'd0;
      end
      ST_SIN_B: sin_x2 <= p14[REM_W-1:0];
      ST_SIN_E: begin
        case (sin_sel)
          2'd0:    sin_r  <= sin_neg ? -sin_mag : sin_mag;
          2'd1:    cos_r  <= sin_neg ? -sin_mag : sin_mag;
          default: fb_cos <= sin_neg ? -sin_mag : sin_mag;
        endcase
        sin_sel <= sin_sel + 2'd1;
        wsel    <= 1'b0;
      end
      ST_W_INIT: begin
        w_fin     <= (w_sm != 0);
        w_tex     <= CELL_W'(1);
        w_q       <= '0;
        w_acr     <= '0;
        w_i       <= '0;
        w_cm      <= w_dir_pos ? (LINE_W'(w_pm[POS_W-1:POS_FRAC]) + LINE_W'(1))
                               : (LINE_W'(w_pm[POS_W-1:POS_FRAC]) - LINE_W'(1));
        div_quo   <= DIV_W'(w_f) << 20;
        div_rem   <= '0;
        div_den   <= DIV_W'(w_den);
        div_cnt   <= '0;
        ret_state <= ST_W_Q0;
      end
      ST_W_Q0: begin
        w_q       <= div_quo;
        w_r       <= div_rem[REM_W-1:0];
        div_quo   <= DIV_W'(1) << 30;
        div_rem   <= '0;
        div_cnt   <= '0;
        ret_state <= ST_W_STEP;
      end
      ST_W_STEP: begin
        w_bq      <= div_quo;
        w_br      <= div_rem[REM_W-1:0];
        wm_a      <= w_q;
        wm_b      <= MUL_B_W'(w_sc);
        ret_state <= ST_W_P0;
      end
      ST_W_P0: begin
        w_p       <= wm_res;
        wm_a      <= w_bq;
        ret_state <= ST_W_QSC;
      end
      ST_W_QSC: w_qsc <= wm_res;
      ST_W_ACR: w_acr <= w_acr_next;
      ST_W_LOOK: w_inr <= w_in_map;
      ST_W_TEST: begin
        if (w_v != '0) begin
          w_tex <= w_v;
        end else begin
          // Next crossing: numerator grows by one full cell
          w_i  <= w_i + 1'b1;
          w_cm <= w_dir_pos ? (w_cm + LINE_W'(1)) : (w_cm - LINE_W'(1));
          if (w_carry) begin
            w_q <= w_q + w_bq + DIV_W'(1);
            w_r <= REM_W'(w_rsum - {1'b0, w_den});
            w_p <= w_p + w_qsc + WIDE_W'(w_sc);
          end else begin
            w_q <= w_q + w_bq;
            w_r <= w_rsum[REM_W-1:0];
            w_p <= w_p + w_qsc;
          end
        end
      end
      ST_W_END: begin
        if (wsel) begin
          v_dist <= w_q;
          v_frac <= w_acr[15:0];
          v_tex  <= w_tex;
          v_fin  <= w_fin;
        end else begin
          h_dist <= w_q;
          h_frac <= w_acr[15:0];
          h_tex  <= w_tex;
          h_fin  <= w_fin;
        end
        wsel <= ~wsel;
      end
      ST_PICK: begin
        r_tex     <= use_vert ? v_tex : h_tex;
        r_vert    <= use_vert;
        r_off     <= (off17[16:6] > 11'd1023) ? OFFSET_W'(1023) : off17[15:6];
        wm_a      <= use_vert ? v_dist : h_dist;
        wm_b      <= MUL_B_W'(fb_cos);
        ret_state <= ST_CORR;
      end
      ST_CORR: corr <= corr_w[WIDE_W-1] ? '0 : corr_w[DIV_W-1:0];
      ST_PH: begin
        r_ph      <= '1;
        div_quo   <= DIV_W'(screen_distance) << 16;
        div_rem   <= '0;
        div_den   <= corr;
        div_cnt   <= '0;
        ret_state <= ST_PH_DONE;
      end
      ST_PH_DONE: r_ph <= (div_quo[DIV_W-1:HEIGHT_W] != '0) ? '1 : div_quo[HEIGHT_W-1:0];
      ST_OUT: begin
        if (!out_valid || rsp.ready) begin
          out_depth  <= (corr[DIV_W-1:24] != '0) ? '1 : corr[23:8];
          out_height <= r_ph;
          out_tex    <= r_tex;
          out_off    <= r_off;
          out_vert   <= r_vert;
        end
      end
      ST_DIV: begin
        div_rem <= div_ge ? DIV_W'(div_sh - {1'b0, div_den}) : div_sh[DIV_W-1:0];
        div_quo <= {div_quo[DIV_W-2:0], div_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      ST_WM_HI:  wm_acc <= prod;
      ST_WM_SUM: wm_res <= WIDE_W'(wm_acc) + (WIDE_W'(prod) <<< SPLIT);
      default: ;
    endcase
  end

endmodule

@@ design/grc_checker.sv @@
module grc_checker import grc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                req_op,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [DEPTH_W-1:0]  rsp_depth,
  input logic [HEIGHT_W-1:0] rsp_height,
  input logic [CELL_W-1:0]   rsp_tex,
  input logic [OFFSET_W-1:0] rsp_off,
  input logic                rsp_vert
);

  // Result word holds while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_depth) && $stable(rsp_height) &&
      $stable(rsp_tex) && $stable(rsp_off) && $stable(rsp_vert))
    else $error("result word changed while stalled");

  // Map sweep follows reset
  a_clear: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("word taken during map clear");

  // A cast occupies the walker
  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_op |=> !req_ready)
    else $error("word taken while a cast is running");

  // Texture is a hit code or the no-hit default
  a_tex: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_tex != '0)
    else $error("empty texture code reported");

endmodule

bind grid_ray_caster grc_checker u_grc_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_op     (req.op),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_depth  (rsp.depth),
  .rsp_height (rsp.wall_height),
  .rsp_tex    (rsp.wall_code),
  .rsp_off    (rsp.hit_offset),
  .rsp_vert   (rsp.hit_vertical)
);
